[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge once reset is released.
`define PLIST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every rising clk edge, reset included.
`define PLIST_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/plist_pkg.sv]
package plist_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = ((CNT_W > 7) ? CNT_W : 7) + 1;
	localparam int ELEM_W   = 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_LOCATE = 2'd3
	} plist_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PUT,
		ST_DONE
	} plist_state_t;

endpackage

[rtl/plist_ram.sv]
module plist_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/positional_list_engine.sv]
// Dense ordered list of up to plist_pkg::CAPACITY bytes (64) kept in one
// single-port-read, single-port-write RAM with a fill count. One request is
// handled at a time: insert, delete, get by position or locate by value, each
// answered by exactly one result word carrying ok, the element, the match
// position, the new count and an empty flag. The memory read port walks one
// element per cycle: get reads its one element, delete reads from the position
// up to the tail, insert from the tail down to the position and locate the
// whole list; an append at count + 1 and a locate in an empty list read
// nothing, and a rejected request (bad position, insert into a full list)
// skips the walk.
// The next request is taken once the result word has been staged, so a result
// may wait on out_stall while the next request already runs. Reset empties
// the list; no clearing pass is needed because only entries below the count
// are ever read.
module positional_list_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [6:0] position,
	input  logic [7:0] value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       ok,
	output logic [7:0] elem_out,
	output logic [6:0] found_at,
	output logic [6:0] count,
	output logic       is_empty
);

	localparam int AW = plist_pkg::ADDR_W;
	localparam int CW = plist_pkg::CNT_W;
	localparam int PW = plist_pkg::CMP_W;
	localparam int EW = plist_pkg::ELEM_W;

	plist_pkg::plist_state_t state_q, state_d;

	// request context, held for the whole walk, and the element and match found
	plist_pkg::plist_op_t op_q;
	logic [AW-1:0]        pa_q;
	logic [EW-1:0]        val_q;
	logic                 ok_q;
	logic [EW-1:0]        elem_q;
	logic [CW-1:0]        found_q;
	logic                 hit_q;

	// walk control
	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic [AW-1:0] cur_q;
	logic          up_q;
	logic          first_q;

	// read pipeline: one stage for the registered RAM output
	logic          rd_valid_s1;
	logic [AW-1:0] rd_addr_s1;
	logic          rd_first_s1;

	// result word
	logic          out_valid_q;
	logic          ok_q2;
	logic [EW-1:0] elem_out_q;
	logic [6:0]    found_at_q;
	logic [6:0]    count_out_q;
	logic          empty_q;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [EW-1:0] ram_rdata;

	// request decode
	logic          accept;
	logic          issue;
	logic          scan_end;
	logic          out_load;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;
	logic          pos_nz;
	logic          req_ok;
	logic [CW-1:0] rem_init;
	logic [AW-1:0] cur_init;
	logic          up_init;
	plist_pkg::plist_op_t req_op;

	assign req_op   = plist_pkg::plist_op_t'(func);
	assign accept   = in_valid && (state_q == plist_pkg::ST_IDLE);
	assign in_stall = (state_q != plist_pkg::ST_IDLE);
	assign issue    = (state_q == plist_pkg::ST_SCAN) && (rem_q != '0);
	assign scan_end = (state_q == plist_pkg::ST_SCAN) && (rem_q == '0) && !rd_valid_s1;
	assign out_load = (state_q == plist_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	assign pos_w  = PW'(position);
	assign cnt_w  = PW'(count_q);
	assign pos_nz = (position != '0);

	// Validate the request and set up the walk: the range of addresses to read
	// and its direction. Insert walks down from the tail, the rest walk up.
	always_comb begin
		req_ok   = 1'b0;
		rem_init = '0;
		cur_init = '0;
		up_init  = 1'b1;
		case (req_op)
			plist_pkg::OP_INSERT: begin
				req_ok   = pos_nz && (pos_w <= cnt_w + PW'(1))
					&& (cnt_w < PW'(plist_pkg::CAPACITY));
				rem_init = CW'(cnt_w - pos_w + PW'(1));
				cur_init = AW'(cnt_w - PW'(1));
				up_init  = 1'b0;
			end
			plist_pkg::OP_DELETE: begin
				req_ok   = pos_nz && (pos_w <= cnt_w);
				rem_init = CW'(cnt_w - pos_w + PW'(1));
				cur_init = AW'(pos_w - PW'(1));
			end
			plist_pkg::OP_GET: begin
				req_ok   = pos_nz && (pos_w <= cnt_w);
				rem_init = CW'(1);
				cur_init = AW'(pos_w - PW'(1));
			end
			plist_pkg::OP_LOCATE: begin
				req_ok   = 1'b1;
				rem_init = count_q;
				cur_init = '0;
			end
			default: begin
				req_ok = 1'b0;
			end
		endcase
	end

	// Sequencer: a rejected request skips the walk; insert adds one write
	// of the new byte after the shift has drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plist_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			plist_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = req_ok ? plist_pkg::ST_SCAN : plist_pkg::ST_DONE;
				end
			end
			plist_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = (op_q == plist_pkg::OP_INSERT) ? plist_pkg::ST_PUT
						: plist_pkg::ST_DONE;
				end
			end
			plist_pkg::ST_PUT: begin
				state_d = plist_pkg::ST_DONE;
			end
			plist_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = plist_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = plist_pkg::ST_IDLE;
			end
		endcase
	end

	// Write port: shift words written in the cycle after their read, then the
	// inserted byte. Insert reads descend and write one above; delete reads
	// ascend and write one below, so no read ever sees a pending write.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_addr_s1;
		ram_wdata = ram_rdata;
		if (state_q == plist_pkg::ST_PUT) begin
			ram_we    = 1'b1;
			ram_waddr = pa_q;
			ram_wdata = val_q;
		end else if (rd_valid_s1) begin
			if (op_q == plist_pkg::OP_INSERT) begin
				ram_we    = 1'b1;
				ram_waddr = rd_addr_s1 + AW'(1);
			end else if (op_q == plist_pkg::OP_DELETE && !rd_first_s1) begin
				ram_we    = 1'b1;
				ram_waddr = rd_addr_s1 - AW'(1);
			end
		end
	end

	plist_ram #(
		.WIDTH(EW),
		.DEPTH(plist_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cur_q),
		.rdata(ram_rdata)
	);

	// walk control and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rem_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (accept) begin
				rem_q <= rem_init;
			end else if (issue) begin
				rem_q <= rem_q - CW'(1);
			end
			if (scan_end && op_q == plist_pkg::OP_DELETE) begin
				count_q <= count_q - CW'(1);
			end else if (state_q == plist_pkg::ST_PUT) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// request context and read data capture
	always_ff @(posedge clk) begin
		rd_addr_s1  <= cur_q;
		rd_first_s1 <= first_q;
		if (accept) begin
			op_q    <= req_op;
			pa_q    <= AW'(pos_w - PW'(1));
			val_q   <= value;
			ok_q    <= req_ok;
			cur_q   <= cur_init;
			up_q    <= up_init;
			first_q <= 1'b1;
			elem_q  <= '0;
			found_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (issue) begin
				cur_q   <= up_q ? cur_q + AW'(1) : cur_q - AW'(1);
				first_q <= 1'b0;
			end
			if (rd_valid_s1) begin
				if (op_q == plist_pkg::OP_GET
					|| (op_q == plist_pkg::OP_DELETE && rd_first_s1)) begin
					elem_q <= ram_rdata;
				end
				// keep the first match only
				if (op_q == plist_pkg::OP_LOCATE && !hit_q && ram_rdata == val_q) begin
					hit_q   <= 1'b1;
					found_q <= CW'(rd_addr_s1) + CW'(1);
				end
			end
		end
	end

	// Result register: hold while stalled, load when done and free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ok_q2       <= ok_q;
			elem_out_q  <= elem_q;
			found_at_q  <= 7'(found_q);
			count_out_q <= 7'(count_q);
			empty_q     <= (count_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q2;
	assign elem_out  = elem_out_q;
	assign found_at  = found_at_q;
	assign count     = count_out_q;
	assign is_empty  = empty_q;

endmodule

[rtl/plist_checker.sv]
`include "assert_macros.svh"

module plist_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       ok,
	input logic [7:0] elem_out,
	input logic [6:0] found_at,
	input logic [6:0] count,
	input logic       is_empty
);

	// hold a stalled result word
	`PLIST_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(count) && $stable(ok), "stalled result word changed")

	// empty flag agrees with the count
	`PLIST_ASSERT(a_empty_flag, out_valid |-> is_empty == (count == 7'd0), "empty flag disagrees with count")

	// a failed request reports neither element nor match
	`PLIST_ASSERT(a_fail_clean, out_valid && !ok |-> elem_out == 8'd0 && found_at == 7'd0, "failed request carries data")

	// one request at a time: stall right after an accepted word
	`PLIST_ASSERT(a_one_inflight, in_valid && !in_stall |=> in_stall, "second word taken while busy")

	// no result valid right after reset is seen asserted
	`PLIST_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "result valid after reset")

endmodule

bind positional_list_engine plist_checker u_plist_checker (.*);
